@@ sv/sfrq_pkg.sv @@
package sfrq_pkg;

   // Queue depth and the widths that follow from it.
   localparam int CAPACITY = 16;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Field widths of the channels and registers.
   localparam int ID_W = 16;
   localparam int SIZE_W = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int LIMIT_W = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Operation codes of an input word.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP = 1'b1;

   // Service orders.
   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_SMALLEST = 1'b1;

   // Register indexes, taken from address bit 2.
   localparam logic REG_SCHED_MODE = 1'b0;
   localparam logic REG_QUEUE_LIMIT = 1'b1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   // Commands broadcast to the cell chain.
   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_PUSH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_ROTATE = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic [1:0] op;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] kill;
   } cell_ctrl_type;

   typedef struct packed {
      logic sched_mode;
      logic [LIMIT_W-1:0] queue_limit;
   } cfg_type;

   typedef struct packed {
      logic accepted;
      logic [ID_W-1:0] out_request_id;
      logic [SIZE_W-1:0] out_file_size;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic is_full;
      logic is_empty;
   } rsp_word_type;

endpackage

@@ sv/sfrq_if.sv @@
interface sfrq_req_if;
   import sfrq_pkg::*;

   logic valid;
   logic ready;
   logic func;
   logic [ID_W-1:0] request_id;
   logic [SIZE_W-1:0] file_size;

   modport source (output valid, func, request_id, file_size, input ready);
   modport sink (input valid, func, request_id, file_size, output ready);
endinterface

interface sfrq_rsp_if;
   import sfrq_pkg::*;

   logic valid;
   logic ready;
   logic accepted;
   logic [ID_W-1:0] out_request_id;
   logic [SIZE_W-1:0] out_file_size;
   logic [COUNT_OUT_W-1:0] entry_count;
   logic is_full;
   logic is_empty;

   modport source (output valid, accepted, out_request_id, out_file_size, entry_count,
                   is_full, is_empty, input ready);
   modport sink (input valid, accepted, out_request_id, out_file_size, entry_count,
                 is_full, is_empty, output ready);
endinterface

@@ sv/sfrq_cell.sv @@
module sfrq_cell (
   input  logic clock,
   input  logic [sfrq_pkg::IDX_W-1:0] my_index,
   input  sfrq_pkg::cell_ctrl_type ctrl,
   input  sfrq_pkg::entry_type new_entry,
   input  sfrq_pkg::entry_type next_entry,
   input  sfrq_pkg::entry_type head_entry,
   output sfrq_pkg::entry_type entry
);
   import sfrq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic [CNT_W-1:0] my_pos;

   assign my_pos = CNT_W'(my_index);

   // Each cell decides from its own position what it loads.
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_PUSH: begin
            if (my_pos == ctrl.count) begin
               entry_in = new_entry;
            end
         end
         OP_REMOVE: begin
            if (my_index >= ctrl.kill) begin
               entry_in = next_entry;
            end
         end
         OP_ROTATE: begin
            if (my_pos + 1'b1 < ctrl.count) begin
               entry_in = next_entry;
            end else if (my_pos + 1'b1 == ctrl.count) begin
               entry_in = head_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ sv/sfrq_csr.sv @@
module sfrq_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [sfrq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfrq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sfrq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output sfrq_pkg::cfg_type cfg
);
   import sfrq_pkg::*;

   logic sched_mode_ff;
   logic sched_mode_in;
   logic [LIMIT_W-1:0] queue_limit_ff;
   logic [LIMIT_W-1:0] queue_limit_in;
   logic write_en;
   logic reg_index;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign reg_index = csr_paddr[2];

   // Register write decode.
   always_comb begin
      sched_mode_in = sched_mode_ff;
      queue_limit_in = queue_limit_ff;
      if (write_en) begin
         case (reg_index)
            REG_SCHED_MODE: sched_mode_in = csr_pwdata[0];
            REG_QUEUE_LIMIT: queue_limit_in = csr_pwdata[LIMIT_W-1:0];
            default: sched_mode_in = sched_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sched_mode_ff <= MODE_ARRIVAL;
         queue_limit_ff <= LIMIT_RESET;
      end else begin
         sched_mode_ff <= sched_mode_in;
         queue_limit_ff <= queue_limit_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_index)
         REG_SCHED_MODE: csr_prdata = CSR_DATA_W'(sched_mode_ff);
         REG_QUEUE_LIMIT: csr_prdata = CSR_DATA_W'(queue_limit_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.sched_mode = sched_mode_ff;
   assign cfg.queue_limit = queue_limit_ff;

endmodule

@@ sv/shortest_first_request_queue.sv @@
// Channel   Direction  Role
// req       in         push or pop word: func, request_id, file_size
// rsp       out        result word: accepted, popped entry, count, full, empty
// csr       in/out     APB registers: sched_mode at 0x0, queue_limit at 0x4
//
// A push, a pop in arrival order and a pop on an empty queue load the
// result from the idle state. A smallest-first pop passes the scan and
// drop states: the entries rotate once around the cell ring past a
// running minimum, then the drop state shifts the winner out. Reset is
// synchronous and empties the queue; entry contents are not cleared. The
// result register frees the input side once the previous word is taken.
module shortest_first_request_queue (
   input  logic clock,
   input  logic reset,
   sfrq_req_if.sink req,
   sfrq_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [sfrq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfrq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sfrq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import sfrq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   cfg_type cfg;
   cell_ctrl_type ctrl;
   entry_type cell_q [CAPACITY];
   entry_type head;
   entry_type new_entry;

   logic [1:0] state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   entry_type best_ff, best_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic [CNT_W-1:0] eff_limit;
   logic accept;
   logic rsp_load;

   sfrq_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   // Ring of entry cells; slot 0 holds the oldest entry.
   assign new_entry.id = req.request_id;
   assign new_entry.size = req.file_size;
   assign head = cell_q[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sfrq_cell u_cell (
         .clock(clock),
         .my_index(IDX_W'(i)),
         .ctrl(ctrl),
         .new_entry(new_entry),
         .next_entry(cell_q[(i + 1) % CAPACITY]),
         .head_entry(head),
         .entry(cell_q[i])
      );
   end

   // A zero or oversized limit means full capacity.
   always_comb begin
      if (cfg.queue_limit == '0 || int'(cfg.queue_limit) > CAPACITY) begin
         eff_limit = CNT_W'(CAPACITY);
      end else begin
         eff_limit = CNT_W'(cfg.queue_limit);
      end
   end

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);

   // Sequencer: push, pop and the minimum scan.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in = step_ff;
      best_in = best_ff;
      best_idx_in = best_idx_ff;
      ctrl.op = OP_HOLD;
      ctrl.count = count_ff;
      ctrl.kill = '0;
      rsp_load = 1'b0;
      rsp_word_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.func == FUNC_PUSH) begin
                  rsp_load = 1'b1;
                  if (count_ff < eff_limit) begin
                     ctrl.op = OP_PUSH;
                     count_in = count_ff + 1'b1;
                     rsp_word_in.accepted = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_load = 1'b1;
               end else if (cfg.sched_mode == MODE_ARRIVAL) begin
                  ctrl.op = OP_REMOVE;
                  count_in = count_ff - 1'b1;
                  rsp_load = 1'b1;
                  rsp_word_in.accepted = 1'b1;
                  rsp_word_in.out_request_id = head.id;
                  rsp_word_in.out_file_size = head.size;
               end else begin
                  state_in = ST_SCAN;
                  step_in = '0;
               end
            end
         end
         ST_SCAN: begin
            // The head cell is compared and the ring turns by one slot.
            ctrl.op = OP_ROTATE;
            if (step_ff == '0 || head.size < best_ff.size) begin
               best_in = head;
               best_idx_in = step_ff;
            end
            if (CNT_W'(step_ff) == count_ff - 1'b1) begin
               state_in = ST_DROP;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DROP: begin
            ctrl.op = OP_REMOVE;
            ctrl.kill = best_idx_ff;
            count_in = count_ff - 1'b1;
            rsp_load = 1'b1;
            rsp_word_in.accepted = 1'b1;
            rsp_word_in.out_request_id = best_ff.id;
            rsp_word_in.out_file_size = best_ff.size;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_word_in.entry_count = COUNT_OUT_W'(count_in);
      rsp_word_in.is_full = (count_in >= eff_limit);
      rsp_word_in.is_empty = (count_in == '0);
   end

   // Result register valid.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      best_idx_ff <= best_idx_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.accepted = rsp_word_ff.accepted;
   assign rsp.out_request_id = rsp_word_ff.out_request_id;
   assign rsp.out_file_size = rsp_word_ff.out_file_size;
   assign rsp.entry_count = rsp_word_ff.entry_count;
   assign rsp.is_full = rsp_word_ff.is_full;
   assign rsp.is_empty = rsp_word_ff.is_empty;

endmodule
